[rtl/core/tlcs_pkg.sv]
// ----------------------------------------------------------------------------
// tlcs_pkg
// Shared types, widths and codes of the tolerant LCS desync finder.
// ----------------------------------------------------------------------------
package tlcs_pkg;

  localparam int MAX_REF_DEF     = 32;
  localparam int MAX_SHIFTED_DEF = 32;

  localparam int TIME_W = 32;
  localparam int TOL_W  = 24;
  localparam int OPC_W  = 2;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 5;
  localparam int GRP_W  = 5;
  localparam int LEN_W  = 6;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_REF = 2'd0,
    OP_LOAD_SH  = 2'd1,
    OP_RUN      = 2'd2
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REF  = 2'd0,
    KIND_SH   = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic clear;
  } gap_ctl_t;

endpackage

[rtl/core/tlcs_gap_list.sv]
// ----------------------------------------------------------------------------
// tlcs_gap_list
// Start-time list kept as gaps to the previous start, with fill count.
// ----------------------------------------------------------------------------
module tlcs_gap_list #(
  parameter int DEPTH = tlcs_pkg::MAX_REF_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlcs_pkg::gap_ctl_t            ctl,
  input  logic [tlcs_pkg::TIME_W-1:0]   start_time,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [tlcs_pkg::TIME_W-1:0]   rd_gap,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [tlcs_pkg::TIME_W-1:0] mem [DEPTH];
  logic [tlcs_pkg::TIME_W-1:0] last_r;
  logic [tlcs_pkg::TIME_W-1:0] q_r;
  logic [CW-1:0]               count_r;
  logic [tlcs_pkg::TIME_W-1:0] gap;
  logic                        wr;

  assign wr = ctl.load && (count_r < CW'(DEPTH));

  always_comb begin
    if (count_r == '0) begin
      gap = '0;
    end else if (start_time >= last_r) begin
      gap = start_time - last_r;
    end else begin
      gap = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
    end else if (wr) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[count_r[AW-1:0]] <= gap;
      last_r               <= start_time;
    end
    q_r <= mem[rd_addr];
  end

  assign rd_gap = q_r;
  assign count  = count_r;

endmodule

[rtl/core/tlcs_match_unit.sv]
// ----------------------------------------------------------------------------
// tlcs_match_unit
// Shared gap comparator: absolute gap difference against the tolerance.
// ----------------------------------------------------------------------------
module tlcs_match_unit (
  input  logic [tlcs_pkg::TIME_W-1:0] gap_a,
  input  logic [tlcs_pkg::TIME_W-1:0] gap_b,
  input  logic [tlcs_pkg::TOL_W-1:0]  tol,
  output logic                        hit
);

  logic [tlcs_pkg::TIME_W-1:0] d_ab;
  logic [tlcs_pkg::TIME_W-1:0] d_ba;
  logic [tlcs_pkg::TIME_W-1:0] diff;

  assign d_ab = gap_a - gap_b;
  assign d_ba = gap_b - gap_a;
  assign diff = (gap_a > gap_b) ? d_ab : d_ba;
  assign hit  = diff <= {{(tlcs_pkg::TIME_W - tlcs_pkg::TOL_W){1'b0}}, tol};

endmodule

[rtl/core/tlcs_len_table.sv]
// ----------------------------------------------------------------------------
// tlcs_len_table
// LCS length table, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlcs_len_table #(
  parameter int RW = 5,
  parameter int SW = 5
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [RW+SW-1:0]            wr_addr,
  input  logic [tlcs_pkg::LEN_W-1:0]  wr_data,
  input  logic [RW+SW-1:0]            rd_addr,
  output logic [tlcs_pkg::LEN_W-1:0]  rd_data
);

  logic [tlcs_pkg::LEN_W-1:0] mem [2**(RW+SW)];
  logic [tlcs_pkg::LEN_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  assign rd_data = q_r;

endmodule

[rtl/core/tolerant_lcs_desync_finder.sv]
// ----------------------------------------------------------------------------
// tolerant_lcs_desync_finder
// Gap-based LCS between two start-time lists, reporting desync groups.
// ----------------------------------------------------------------------------
// Load transactions are taken one per cycle. A run transaction holds in_stall
// high until its done item sits in the output register: the table fill
// reads the row below each cell, then compares and writes the cell into the
// table; the traceback takes at most n+m steps and emits pending indices
// between steps, where the sink can stall it. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module tolerant_lcs_desync_finder #(
  parameter int MAX_REF     = tlcs_pkg::MAX_REF_DEF,
  parameter int MAX_SHIFTED = tlcs_pkg::MAX_SHIFTED_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tlcs_pkg::TOL_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlcs_pkg::OPC_W-1:0]    in_opcode,
  input  logic [tlcs_pkg::TIME_W-1:0]   in_start_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlcs_pkg::KIND_W-1:0]   out_kind,
  output logic [tlcs_pkg::IDX_W-1:0]    out_element_index,
  output logic [tlcs_pkg::GRP_W-1:0]    out_group_number,
  output logic                          out_group_last
);

  localparam int RW  = $clog2(MAX_REF);
  localparam int SW  = $clog2(MAX_SHIFTED);
  localparam int CRW = $clog2(MAX_REF + 1);
  localparam int CSW = $clog2(MAX_SHIFTED + 1);
  localparam int KW  = (CRW > CSW) ? CRW : CSW;
  localparam int LW  = tlcs_pkg::LEN_W;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_F_RD   = 9'b000000010,
    ST_F_WR   = 9'b000000100,
    ST_TB_RD  = 9'b000001000,
    ST_TB_EV  = 9'b000010000,
    ST_TB_EV2 = 9'b000100000,
    ST_EM_R   = 9'b001000000,
    ST_EM_S   = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CRW-1:0]              i_r, i_nxt, rp_r, rp_nxt;
  logic [CSW-1:0]              j_r, j_nxt, sp_r, sp_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [tlcs_pkg::GRP_W-1:0]  grp_r, grp_nxt;
  logic [LW-1:0]               right_r, right_nxt, diag_r, diag_nxt;
  logic [LW-1:0]               cur_len_r, cur_len_nxt;
  logic [tlcs_pkg::TOL_W-1:0]  tol_r;

  logic                        out_valid_r, out_valid_nxt;
  tlcs_pkg::kind_t             out_kind_r, out_kind_nxt;
  logic [tlcs_pkg::IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [tlcs_pkg::GRP_W-1:0]  out_grp_r, out_grp_nxt;
  logic                        out_last_r, out_last_nxt;

  tlcs_pkg::gap_ctl_t          ref_ctl, sh_ctl;
  tlcs_pkg::opcode_t           opc;
  logic [tlcs_pkg::TIME_W-1:0] ref_gap, sh_gap;
  logic [CRW-1:0]              ref_cnt, i_plus, ref_pos;
  logic [CSW-1:0]              sh_cnt, j_plus, sh_pos;
  logic                        in_accept, out_free, hit, done_fire, ref_end, sh_end;
  logic [LW-1:0]               tbl_q, down_len, fill_v, best;
  logic                        tbl_wr;
  logic [RW+SW-1:0]            tbl_wr_addr, tbl_rd_addr;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign opc       = tlcs_pkg::opcode_t'(in_opcode);
  assign done_fire = (state_r == ST_DONE) && out_free;

  always_comb begin
    ref_ctl = '0;
    sh_ctl  = '0;
    unique case (opc)
      tlcs_pkg::OP_LOAD_REF: ref_ctl.load = in_accept;
      tlcs_pkg::OP_LOAD_SH:  sh_ctl.load  = in_accept;
      default: ;
    endcase
    ref_ctl.clear = done_fire;
    sh_ctl.clear  = done_fire;
  end

  tlcs_gap_list #(.DEPTH(MAX_REF)) u_ref_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ref_ctl),
    .start_time (in_start_time),
    .rd_addr    (i_r[RW-1:0]),
    .rd_gap     (ref_gap),
    .count      (ref_cnt)
  );

  tlcs_gap_list #(.DEPTH(MAX_SHIFTED)) u_sh_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sh_ctl),
    .start_time (in_start_time),
    .rd_addr    (j_r[SW-1:0]),
    .rd_gap     (sh_gap),
    .count      (sh_cnt)
  );

  tlcs_match_unit u_match (
    .gap_a (ref_gap),
    .gap_b (sh_gap),
    .tol   (tol_r),
    .hit   (hit)
  );

  assign i_plus  = i_r + CRW'(1);
  assign j_plus  = j_r + CSW'(1);
  assign ref_end = (i_plus == ref_cnt);
  assign sh_end  = (j_plus == sh_cnt);

  // row below the table is the all-ones border
  assign down_len = ref_end ? LW'(1) : tbl_q;
  assign best     = (down_len > right_r) ? down_len : right_r;
  assign fill_v   = hit ? (diag_r + LW'(1)) : best;

  assign tbl_wr      = (state_r == ST_F_WR);
  assign tbl_wr_addr = {i_r[RW-1:0], j_r[SW-1:0]};
  assign tbl_rd_addr = ((state_r == ST_F_RD) || (state_r == ST_TB_EV)) ?
                       {i_plus[RW-1:0], j_r[SW-1:0]} : {i_r[RW-1:0], j_r[SW-1:0]};

  tlcs_len_table #(.RW(RW), .SW(SW)) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_wr_addr),
    .wr_data (fill_v),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_q)
  );

  assign ref_pos = i_r - rp_r + CRW'(k_r);
  assign sh_pos  = j_r - sp_r + CSW'(k_r);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rp_nxt        = rp_r;
    sp_nxt        = sp_r;
    k_nxt         = k_r;
    grp_nxt       = grp_r;
    right_nxt     = right_r;
    diag_nxt      = diag_r;
    cur_len_nxt   = cur_len_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_grp_nxt   = out_grp_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (opc == tlcs_pkg::OP_RUN)) begin
          rp_nxt  = '0;
          sp_nxt  = '0;
          grp_nxt = '0;
          if ((ref_cnt == '0) || (sh_cnt == '0)) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt     = ref_cnt - CRW'(1);
            j_nxt     = sh_cnt - CSW'(1);
            right_nxt = LW'(1);
            diag_nxt  = LW'(1);
            state_nxt = ST_F_RD;
          end
        end
      end
      ST_F_RD: state_nxt = ST_F_WR;
      ST_F_WR: begin
        state_nxt = ST_F_RD;
        if (j_r == '0) begin
          if (i_r == '0) begin
            state_nxt = ST_TB_RD;
          end else begin
            i_nxt     = i_r - CRW'(1);
            j_nxt     = sh_cnt - CSW'(1);
            right_nxt = LW'(1);
            diag_nxt  = LW'(1);
          end
        end else begin
          j_nxt     = j_r - CSW'(1);
          right_nxt = fill_v;
          diag_nxt  = down_len;
        end
      end
      ST_TB_RD: state_nxt = ST_TB_EV;
      ST_TB_EV: begin
        if (hit) begin
          if ((rp_r != '0) && (sp_r != '0)) begin
            k_nxt     = '0;
            state_nxt = ST_EM_R;
          end else begin
            i_nxt     = i_plus;
            j_nxt     = j_plus;
            rp_nxt    = '0;
            sp_nxt    = '0;
            state_nxt = (ref_end || sh_end) ? ST_DONE : ST_TB_RD;
          end
        end else begin
          cur_len_nxt = tbl_q;
          state_nxt   = ST_TB_EV2;
        end
      end
      ST_TB_EV2: begin
        if (cur_len_r == down_len) begin
          i_nxt     = i_plus;
          rp_nxt    = rp_r + CRW'(1);
          state_nxt = ref_end ? ST_DONE : ST_TB_RD;
        end else begin
          j_nxt     = j_plus;
          sp_nxt    = sp_r + CSW'(1);
          state_nxt = sh_end ? ST_DONE : ST_TB_RD;
        end
      end
      ST_EM_R: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tlcs_pkg::KIND_REF;
          out_idx_nxt   = tlcs_pkg::IDX_W'(ref_pos[RW-1:0]);
          out_grp_nxt   = grp_r;
          out_last_nxt  = 1'b0;
          if ((CRW'(k_r) + CRW'(1)) == rp_r) begin
            k_nxt     = '0;
            state_nxt = ST_EM_S;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      ST_EM_S: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tlcs_pkg::KIND_SH;
          out_idx_nxt   = tlcs_pkg::IDX_W'(sh_pos[SW-1:0]);
          out_grp_nxt   = grp_r;
          out_last_nxt  = ((CSW'(k_r) + CSW'(1)) == sp_r);
          if ((CSW'(k_r) + CSW'(1)) == sp_r) begin
            grp_nxt   = grp_r + tlcs_pkg::GRP_W'(1);
            i_nxt     = i_plus;
            j_nxt     = j_plus;
            rp_nxt    = '0;
            sp_nxt    = '0;
            state_nxt = (ref_end || sh_end) ? ST_DONE : ST_TB_RD;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tlcs_pkg::KIND_DONE;
          out_idx_nxt   = '0;
          out_grp_nxt   = '0;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rp_r       <= rp_nxt;
    sp_r       <= sp_nxt;
    k_r        <= k_nxt;
    grp_r      <= grp_nxt;
    right_r    <= right_nxt;
    diag_r     <= diag_nxt;
    cur_len_r  <= cur_len_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_grp_r  <= out_grp_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_element_index = out_idx_r;
  assign out_group_number  = out_grp_r;
  assign out_group_last    = out_last_r;

  a_last_on_shifted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_group_last) |-> (out_kind == tlcs_pkg::KIND_SH))
    else $error("group_last on a non-shifted item");

  a_tb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TB_RD) |-> ((i_r < ref_cnt) && (j_r < sh_cnt)))
    else $error("traceback position outside the lists");

  a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> ((ref_cnt == '0) && (sh_cnt == '0)))
    else $error("list counts not cleared after done");

  a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TB_RD) |-> ((rp_r <= i_r) && (sp_r <= j_r)))
    else $error("pending run larger than traversed span");

endmodule
